[rtl/core/tfs_pkg.sv]
`default_nettype none
package tfs_pkg;

    localparam int FRAME_LEN = 48;
    localparam int BODY_LEN  = 46;
    localparam int HDR_LEN   = 6;
    localparam int NUM_WORDS = 10;
    localparam int WORD_W    = 32;
    localparam int IDX_W     = $clog2(FRAME_LEN);

    localparam logic [7:0]  MAGIC_A   = 8'h42;
    localparam logic [7:0]  MAGIC_B   = 8'h43;
    localparam logic [7:0]  VERSION   = 8'h01;
    localparam logic [7:0]  SIZE_BYTE = 8'(FRAME_LEN);
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    localparam logic [IDX_W-1:0] POS_MAGIC_A = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_MAGIC_B = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_VERSION = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_SIZE    = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_SEQ_LO  = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_SEQ_HI  = IDX_W'(5);
    localparam logic [IDX_W-1:0] POS_BODY    = IDX_W'(HDR_LEN);
    localparam logic [IDX_W-1:0] POS_CRC_LO  = IDX_W'(BODY_LEN);
    localparam logic [IDX_W-1:0] POS_CRC_HI  = IDX_W'(FRAME_LEN - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } state_t;

    typedef struct packed {
        logic init;
        logic update;
    } crc_ctl_t;

    typedef struct packed {
        logic load;
        logic advance;
    } buf_ctl_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/core/tfs_rec_if.sv]
`default_nettype none
interface tfs_rec_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_stamp;
    logic [31:0] roll_angle;
    logic [31:0] roll_target;
    logic [31:0] gyro_rate;
    logic [31:0] gyro_target;
    logic [31:0] wheel_target;
    logic [31:0] left_wheel;
    logic [31:0] right_wheel;
    logic [31:0] speed_feedback;
    logic [31:0] speed_correction;
    logic        link_ready;

    modport source (
        output valid, time_stamp, roll_angle, roll_target, gyro_rate, gyro_target,
               wheel_target, left_wheel, right_wheel, speed_feedback, speed_correction,
               link_ready,
        input  ready
    );

    modport sink (
        input  valid, time_stamp, roll_angle, roll_target, gyro_rate, gyro_target,
               wheel_target, left_wheel, right_wheel, speed_feedback, speed_correction,
               link_ready,
        output ready
    );
endinterface
`default_nettype wire

[rtl/core/tfs_frame_if.sv]
`default_nettype none
interface tfs_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (
        output valid, frame_byte, frame_end,
        input  ready
    );

    modport sink (
        input  valid, frame_byte, frame_end,
        output ready
    );
endinterface
`default_nettype wire

[rtl/core/tfs_crc_unit.sv]
`default_nettype none
module tfs_crc_unit
    import tfs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire crc_ctl_t    ctl,
    input  wire logic [7:0]  data,
    output logic      [15:0] crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        priority if (ctl.init)
        begin
            crc_next = CRC_INIT;
        end
        else if (ctl.update)
        begin
            crc_next = crc16_byte(crc_reg, data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule
`default_nettype wire

[rtl/core/tfs_frame_buf.sv]
`default_nettype none
module tfs_frame_buf
    import tfs_pkg::*;
(
    input  wire logic                        clk,
    input  wire buf_ctl_t                    ctl,
    input  wire logic [NUM_WORDS*WORD_W-1:0] words,
    input  wire logic [15:0]                 seq,
    input  wire logic [15:0]                 crc,
    input  wire logic [IDX_W-1:0]            idx,
    output logic      [7:0]                  frame_byte
);

    logic [NUM_WORDS*WORD_W-1:0] shift_reg;
    logic [NUM_WORDS*WORD_W-1:0] shift_next;

    always_comb
    begin
        shift_next = shift_reg;
        priority if (ctl.load)
        begin
            shift_next = words;
        end
        else if (ctl.advance)
        begin
            shift_next = {8'h00, shift_reg[NUM_WORDS*WORD_W-1:8]};
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    always_comb
    begin
        priority if (idx == POS_MAGIC_A)
        begin
            frame_byte = MAGIC_A;
        end
        else if (idx == POS_MAGIC_B)
        begin
            frame_byte = MAGIC_B;
        end
        else if (idx == POS_VERSION)
        begin
            frame_byte = VERSION;
        end
        else if (idx == POS_SIZE)
        begin
            frame_byte = SIZE_BYTE;
        end
        else if (idx == POS_SEQ_LO)
        begin
            frame_byte = seq[7:0];
        end
        else if (idx == POS_SEQ_HI)
        begin
            frame_byte = seq[15:8];
        end
        else if (idx == POS_CRC_LO)
        begin
            frame_byte = crc[7:0];
        end
        else if (idx == POS_CRC_HI)
        begin
            frame_byte = crc[15:8];
        end
        else
        begin
            frame_byte = shift_reg[7:0];
        end
    end

endmodule
`default_nettype wire

[rtl/core/telemetry_frame_serializer_crc16_top.sv]
// The first frame byte is offered in the cycle after the record transfer. One frame
// byte per output transfer, 48 transfers per frame; the next record is taken the
// cycle after the last byte. A record with link_ready low is taken and dropped. The
// CRC unit folds one byte per output transfer up to the last body byte, not the CRC
// bytes. Reset puts the sequencer in idle at index 0 and clears the sequence number.
`default_nettype none
module telemetry_frame_serializer_crc16_top
    import tfs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    tfs_rec_if.sink   rec,
    tfs_frame_if.source frame
);

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [15:0]      seq_reg;
    logic [15:0]      seq_next;
    logic             in_xfer;
    logic             out_xfer;
    logic             last_byte;
    logic [15:0]      crc;
    logic [7:0]       frame_byte;
    crc_ctl_t         crc_ctl;
    buf_ctl_t         buf_ctl;

    assign rec.ready   = (state_reg == ST_IDLE);
    assign frame.valid = (state_reg == ST_SEND);
    assign in_xfer     = rec.valid && rec.ready;
    assign out_xfer    = frame.valid && frame.ready;
    assign last_byte   = (idx_reg == POS_CRC_HI);

    assign buf_ctl.load    = in_xfer && rec.link_ready;
    assign buf_ctl.advance = out_xfer && (idx_reg >= POS_BODY) && (idx_reg < POS_CRC_LO);
    assign crc_ctl.init    = in_xfer && rec.link_ready;
    assign crc_ctl.update  = out_xfer && (idx_reg < POS_CRC_LO);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        seq_next   = seq_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rec.valid && rec.link_ready)
                begin
                    state_next = ST_SEND;
                    idx_next   = '0;
                end
            end
            ST_SEND:
            begin
                if (frame.ready)
                begin
                    if (last_byte)
                    begin
                        state_next = ST_IDLE;
                        idx_next   = '0;
                        seq_next   = seq_reg + 16'd1;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            seq_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            seq_reg   <= seq_next;
        end
    end

    tfs_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .data  (frame_byte),
        .crc   (crc)
    );

    tfs_frame_buf u_buf (
        .clk        (clk),
        .ctl        (buf_ctl),
        .words      ({rec.speed_correction, rec.speed_feedback, rec.right_wheel,
                      rec.left_wheel, rec.wheel_target, rec.gyro_target, rec.gyro_rate,
                      rec.roll_target, rec.roll_angle, rec.time_stamp}),
        .seq        (seq_reg),
        .crc        (crc),
        .idx        (idx_reg),
        .frame_byte (frame_byte)
    );

    assign frame.frame_byte = frame_byte;
    assign frame.frame_end  = last_byte;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid |-> idx_reg <= POS_CRC_HI)
        else $error("frame index beyond last byte");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && rec.link_ready |=> frame.valid && idx_reg == POS_MAGIC_A)
        else $error("accepted record did not start a frame");

    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !rec.link_ready |=> !frame.valid && $stable(seq_reg))
        else $error("dropped record changed state");

    a_seq_inc: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && frame.frame_end |=> seq_reg == 16'($past(seq_reg) + 16'd1))
        else $error("sequence number not advanced after frame");

endmodule
`default_nettype wire
